/* src/cleb_pkg.sv */
// ----------------------------------------------------------------------------
// cleb_pkg: shared types and constants of the cursor line edit buffer
// Word layouts of both channels, key codes and the default capacity.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam int DefaultCapacity = 64;

  localparam logic [7:0] KeyLeft   = 8'h3C;
  localparam logic [7:0] KeyRight  = 8'h3E;
  localparam logic [7:0] KeyDelete = 8'h2D;

  localparam logic OpEdit = 1'b0;
  localparam logic OpDump = 1'b1;

  typedef logic [7:0] char_t;
  typedef logic [6:0] pos_t;

  typedef struct packed {
    logic  opcode;
    char_t key_char;
  } in_word_t;

  typedef struct packed {
    char_t out_char;
    logic  char_valid;
    pos_t  cursor_pos;
    pos_t  text_length;
    char_t char_at_cursor;
    logic  overflow;
    logic  last;
  } out_word_t;

endpackage

/* src/cursor_line_edit_buffer_core.sv */
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_core: line editor with a cursor over a gap buffer
// The text sits in two stack RAMs: left of the cursor and right of it.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry an opcode and a key byte. An edit word ('<', '>', '-'
//   or a byte to insert) gives one result word. A dump word gives one result
//   word per stored character, in text order, with last on the final one;
//   an empty text dumps as a single word with char_valid low.
//   Each result also reports cursor, length and the character at the cursor.
//   An input is taken in S_IDLE; its result is registered from S_EDIT or
//   S_DUMP once the output register is free. An edit passes through S_IDLE
//   and S_EDIT: a stack RAM is read in S_IDLE and written back in S_EDIT.
//   A dump streams one word per cycle after its first read unless stalled.
//   in_stall_o is high while an item is in progress; the next item is taken
//   even while a finished result waits in the output register.
//   With out_stall_i high on a valid result, the word holds and the block waits.
//   Reset empties the text and places the cursor at zero; RAM contents are
//   left as they are, as no entry is read before it is written.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_core #(
  parameter int Capacity = cleb_pkg::DefaultCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cleb_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cleb_pkg::out_word_t out_word_o
);

  localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CW = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EDIT,
    S_DUMP
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LEFT,
    ACT_RIGHT,
    ACT_DEL,
    ACT_INS,
    ACT_OVF
  } act_e;

  state_e              state_q, state_d;
  act_e                act_q, act_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic [CW-1:0]       len_q, len_d;
  logic [CW-1:0]       k_q, k_d;
  cleb_pkg::char_t     top_q, top_d;
  cleb_pkg::char_t     key_q, key_d;
  logic                from_left_q, from_left_d;
  logic                out_valid_q, out_valid_d;
  cleb_pkg::out_word_t out_q, out_d;

  logic [CW-1:0]   r_cnt;
  logic [CW-1:0]   k_nx;
  logic            in_acc;
  logic            out_free;

  logic            l_we, l_re, r_we, r_re;
  logic [AW-1:0]   l_waddr, l_raddr, r_waddr, r_raddr;
  cleb_pkg::char_t l_wdata, r_wdata, l_rdata, r_rdata, dump_char;

  cleb_stack_ram #(.Depth(Capacity), .Width(8)) u_left (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  cleb_stack_ram #(.Depth(Capacity), .Width(8)) u_right (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  assign r_cnt     = len_q - cur_q;
  assign k_nx      = k_q + CW'(1);
  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign dump_char = from_left_q ? l_rdata : r_rdata;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cur_d       = cur_q;
    len_d       = len_q;
    k_d         = k_q;
    top_d       = top_q;
    key_d       = key_q;
    from_left_d = from_left_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    l_we        = 1'b0;
    l_waddr     = cur_q[AW-1:0];
    l_wdata     = key_q;
    l_re        = 1'b0;
    l_raddr     = '0;
    r_we        = 1'b0;
    r_waddr     = r_cnt[AW-1:0];
    r_wdata     = l_rdata;
    r_re        = 1'b0;
    r_raddr     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d = in_word_i.key_char;
          act_d = ACT_NONE;
          state_d = S_EDIT;
          if (in_word_i.opcode == cleb_pkg::OpDump) begin
            if (len_q != '0) begin
              state_d = S_DUMP;
              k_d     = '0;
              if (cur_q != '0) begin
                l_re        = 1'b1;
                l_raddr     = '0;
                from_left_d = 1'b1;
              end else begin
                r_re        = 1'b1;
                r_raddr     = AW'(len_q - CW'(1));
                from_left_d = 1'b0;
              end
            end
          end else if (in_word_i.key_char == cleb_pkg::KeyLeft) begin
            if (cur_q != '0) begin
              act_d   = ACT_LEFT;
              l_re    = 1'b1;
              l_raddr = AW'(cur_q - CW'(1));
            end
          end else if (in_word_i.key_char == cleb_pkg::KeyRight) begin
            if (r_cnt != '0) begin
              act_d = ACT_RIGHT;
              // fetch the character that becomes the new top
              if (r_cnt > CW'(1)) begin
                r_re    = 1'b1;
                r_raddr = AW'(r_cnt - CW'(2));
              end
            end
          end else if (in_word_i.key_char == cleb_pkg::KeyDelete) begin
            if (cur_q != '0) begin
              act_d = ACT_DEL;
            end
          end else if (len_q < CW'(Capacity)) begin
            act_d = ACT_INS;
          end else begin
            act_d = ACT_OVF;
          end
        end
      end

      S_EDIT: begin
        if (out_free) begin
          case (act_q)
            ACT_LEFT: begin
              cur_d = cur_q - CW'(1);
              r_we  = 1'b1;
              top_d = l_rdata;
            end
            ACT_RIGHT: begin
              l_we    = 1'b1;
              l_wdata = top_q;
              cur_d   = cur_q + CW'(1);
              top_d   = (r_cnt > CW'(1)) ? r_rdata : '0;
            end
            ACT_DEL: begin
              cur_d = cur_q - CW'(1);
              len_d = len_q - CW'(1);
            end
            ACT_INS: begin
              l_we  = 1'b1;
              cur_d = cur_q + CW'(1);
              len_d = len_q + CW'(1);
            end
            default: begin
            end
          endcase
          out_valid_d          = 1'b1;
          out_d.out_char       = '0;
          out_d.char_valid     = 1'b0;
          out_d.cursor_pos     = cleb_pkg::pos_t'(cur_d);
          out_d.text_length    = cleb_pkg::pos_t'(len_d);
          out_d.char_at_cursor = top_d;
          out_d.overflow       = (act_q == ACT_OVF);
          out_d.last           = 1'b1;
          state_d              = S_IDLE;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.out_char       = dump_char;
          out_d.char_valid     = 1'b1;
          out_d.cursor_pos     = cleb_pkg::pos_t'(cur_q);
          out_d.text_length    = cleb_pkg::pos_t'(len_q);
          out_d.char_at_cursor = top_q;
          out_d.overflow       = 1'b0;
          out_d.last           = (k_q == len_q - CW'(1));
          if (k_q == len_q - CW'(1)) begin
            state_d = S_IDLE;
          end else begin
            // advance: left stack bottom-up, then right stack top-down
            k_d = k_nx;
            if (k_nx < cur_q) begin
              l_re        = 1'b1;
              l_raddr     = k_nx[AW-1:0];
              from_left_d = 1'b1;
            end else begin
              r_re        = 1'b1;
              r_raddr     = AW'(len_q - CW'(1) - k_nx);
              from_left_d = 1'b0;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_NONE;
      cur_q       <= '0;
      len_q       <= '0;
      k_q         <= '0;
      top_q       <= '0;
      from_left_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      cur_q       <= cur_d;
      len_q       <= len_d;
      k_q         <= k_d;
      top_q       <= top_d;
      from_left_q <= from_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* src/cleb_stack_ram.sv */
// ----------------------------------------------------------------------------
// cleb_stack_ram: one stack store of the edit buffer
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cleb_stack_ram #(
  parameter int Depth = cleb_pkg::DefaultCapacity,
  parameter int Width = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
